// File: rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round functions for the MD5 stream hash.
// Used by md5_ctrl, md5_dpath and md5_stream_hash. No dependencies.
`default_nettype none
package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_80,
		PH_ZERO,
		PH_LEN
	} phase_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_80,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic push;
		src_t src;
		logic count_bits;
		logic comp_start;
		logic out_next;
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       comp_done;
		logic [1:0] word_idx;
	} status_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [1:0] WORD_LAST = 2'd3;
	localparam logic [6:0] STEP_LOAD = 7'd1;
	localparam logic [6:0] STEP_ROUND0 = 7'd2;
	localparam logic [6:0] STEP_ROUND63 = 7'd65;
	localparam logic [6:0] STEP_DONE = 7'd66;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// message word used by a round
	function automatic logic [3:0] word_sel(input logic [5:0] rnd);
		logic [3:0] r;
		begin
			r = rnd[3:0];
			case (rnd[5:4])
				2'd0:    word_sel = r;
				2'd1:    word_sel = 4'((r << 2) + r + 4'd1);
				2'd2:    word_sel = 4'((r << 1) + r + 4'd5);
				default: word_sel = 4'((r << 3) - r);
			endcase
		end
	endfunction

	function automatic logic [4:0] rot_sel(input logic [5:0] rnd);
		case ({rnd[5:4], rnd[1:0]})
			4'd0:    rot_sel = 5'd7;
			4'd1:    rot_sel = 5'd12;
			4'd2:    rot_sel = 5'd17;
			4'd3:    rot_sel = 5'd22;
			4'd4:    rot_sel = 5'd5;
			4'd5:    rot_sel = 5'd9;
			4'd6:    rot_sel = 5'd14;
			4'd7:    rot_sel = 5'd20;
			4'd8:    rot_sel = 5'd4;
			4'd9:    rot_sel = 5'd11;
			4'd10:   rot_sel = 5'd16;
			4'd11:   rot_sel = 5'd23;
			4'd12:   rot_sel = 5'd6;
			4'd13:   rot_sel = 5'd10;
			4'd14:   rot_sel = 5'd15;
			default: rot_sel = 5'd21;
		endcase
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] grp,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		case (grp)
			2'd0:    round_f = (b & c) | (~b & d);
			2'd1:    round_f = (d & b) | (~d & c);
			2'd2:    round_f = b ^ c ^ d;
			default: round_f = c ^ (b | ~d);
		endcase
	endfunction

endpackage
`default_nettype wire

// File: rtl/md5_ctrl.sv
// md5_ctrl: sequencer for byte intake, padding, compression and digest output.
// Depends on md5_pkg; drives md5_dpath through cmd_t and reads status_t.
`default_nettype none
module md5_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_ready,
	input  wire  md5_pkg::item_t  item,
	output logic                  result_valid,
	input  wire                   result_ready,
	input  wire  md5_pkg::status_t stat,
	output md5_pkg::cmd_t         cmd
);
	import md5_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   pad_q, pad_d;
	logic   fin_q, fin_d;
	logic   fill_last;

	assign fill_last = (stat.fill == FILL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_80;
			pad_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pad_q   <= pad_d;
			fin_q   <= fin_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		pad_d   = pad_q;
		fin_d   = fin_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					phase_d = PH_80;
					pad_d   = item.last;
					if (item.byte_valid && fill_last) begin
						state_d = ST_COMP;
					end else if (item.last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				case (phase_q)
					PH_80: begin
						phase_d = PH_ZERO;
						if (fill_last) begin
							state_d = ST_COMP;
						end
					end
					PH_ZERO: begin
						if (stat.fill == LEN_START) begin
							phase_d = PH_LEN;
						end else if (fill_last) begin
							state_d = ST_COMP;
						end
					end
					default: begin
						if (fill_last) begin
							state_d = ST_COMP;
							fin_d   = 1'b1;
						end
					end
				endcase
			end
			ST_COMP: begin
				if (stat.comp_done) begin
					if (fin_q) begin
						state_d = ST_OUT;
					end else if (pad_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_OUT: begin
				if (result_ready && stat.word_idx == WORD_LAST) begin
					state_d = ST_IDLE;
					pad_d   = 1'b0;
					fin_d   = 1'b0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready   = 1'b0;
		result_valid = 1'b0;
		cmd          = '0;
		cmd.src      = SRC_IN;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.push       = item.byte_valid;
					cmd.count_bits = item.byte_valid;
					cmd.comp_start = item.byte_valid && fill_last;
				end
			end
			ST_PAD: begin
				case (phase_q)
					PH_80: begin
						cmd.push       = 1'b1;
						cmd.src        = SRC_80;
						cmd.comp_start = fill_last;
					end
					PH_ZERO: begin
						cmd.push       = (stat.fill != LEN_START);
						cmd.src        = SRC_ZERO;
						cmd.comp_start = fill_last;
					end
					default: begin
						cmd.push       = 1'b1;
						cmd.src        = SRC_LEN;
						cmd.comp_start = fill_last;
					end
				endcase
			end
			ST_OUT: begin
				result_valid = 1'b1;
				cmd.out_next = result_ready;
				cmd.restart  = result_ready && stat.word_idx == WORD_LAST;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/md5_dpath.sv
// md5_dpath: block buffer, bit counter, chaining words and iterative MD5 round unit.
// Depends on md5_pkg; commanded by md5_ctrl.
`default_nettype none
module md5_dpath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [7:0]            in_byte,
	input  wire  md5_pkg::cmd_t   cmd,
	output md5_pkg::status_t      stat,
	output md5_pkg::result_t      result
);
	import md5_pkg::*;

	logic [3:0][7:0] buf_q [16];
	logic [31:0] rdata_q;
	logic [3:0]  raddr;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] akw_q;
	logic [6:0]  step_q;
	logic        busy_q;
	logic [1:0]  idx_q;
	logic [7:0]  wbyte;
	logic [5:0]  rnd;
	logic [5:0]  k_idx;
	logic [31:0] sum;
	logic [31:0] rot;
	logic [63:0] rot_wide;
	logic        in_round;

	always_comb begin
		case (cmd.src)
			SRC_IN:   wbyte = in_byte;
			SRC_80:   wbyte = PAD_BYTE;
			SRC_ZERO: wbyte = '0;
			default:  wbyte = bits_q[{fill_q[2:0], 3'b000} +: 8];
		endcase
	end

	assign raddr = word_sel(step_q[5:0]);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			buf_q[fill_q[5:2]][fill_q[1:0]] <= wbyte;
		end
		rdata_q <= buf_q[raddr];
	end

	assign rnd      = 6'(step_q - STEP_ROUND0);
	assign k_idx    = 6'(step_q - STEP_LOAD);
	assign in_round = busy_q && step_q >= STEP_ROUND0 && step_q <= STEP_ROUND63;
	assign sum      = akw_q + round_f(rnd[5:4], b_q, c_q, d_q);
	assign rot_wide = {sum, sum} << rot_sel(rnd);
	assign rot      = rot_wide[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			bits_q     <= '0;
			busy_q     <= 1'b0;
			step_q     <= '0;
			idx_q      <= '0;
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count_bits) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.comp_start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 7'd1;
				if (step_q == STEP_DONE) begin
					busy_q     <= 1'b0;
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
				end
			end
			if (cmd.out_next) begin
				idx_q <= idx_q + 2'd1;
			end
			if (cmd.restart) begin
				fill_q     <= '0;
				bits_q     <= '0;
				idx_q      <= '0;
				chain_q[0] <= IV_A;
				chain_q[1] <= IV_B;
				chain_q[2] <= IV_C;
				chain_q[3] <= IV_D;
			end
		end
	end

	// working words; akw_q holds next round's a + K + w
	always_ff @(posedge clk) begin
		if (busy_q && step_q == '0) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end
		if (busy_q && step_q == STEP_LOAD) begin
			akw_q <= a_q + rdata_q + ROUND_K[k_idx];
		end
		if (in_round) begin
			akw_q <= d_q + rdata_q + ROUND_K[k_idx];
			a_q   <= d_q;
			d_q   <= c_q;
			c_q   <= b_q;
			b_q   <= b_q + rot;
		end
	end

	assign stat.fill      = fill_q;
	assign stat.comp_done = busy_q && step_q == STEP_DONE;
	assign stat.word_idx  = idx_q;

	assign result.digest_word = chain_q[idx_q];
	assign result.word_index  = idx_q;
	assign result.last_word   = (idx_q == WORD_LAST);

endmodule
`default_nettype wire

// File: rtl/md5_stream_hash.sv
// md5_stream_hash: streaming MD5 engine, top level.
// Depends on md5_pkg, md5_ctrl and md5_dpath.
//
// Usage: requests arrive on item (valid/ready), one message byte each, with
// byte_valid marking a real byte and last ending the message. A request with
// byte_valid low and last low has no effect.
// Bytes are taken one per cycle while item_ready is high. The 64th byte of a
// block starts a compression (one MD5 round per cycle in the shared round
// unit, plus buffer read and chaining add), during which item_ready is low.
// On last the engine pads through the length field (0x80, zero bytes, then the
// 64-bit bit count, low byte first), with one compression, or two when the
// padding spills into a second block, then presents the four digest words
// A..D on result, one per accepted transfer; word_index gives the word and
// last_word marks D. Digest bytes are each word's bytes, low first.
// A receiver stall simply holds the current word; no new request is taken
// until all four words have gone, after which a new message starts.
// Reset (arst_n low) loads the MD5 initial values and clears the byte and bit
// counts; the block buffer is not cleared.
`default_nettype none
module md5_stream_hash (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_ready,
	input  wire  md5_pkg::item_t   item,
	output logic                   result_valid,
	input  wire                    result_ready,
	output md5_pkg::result_t       result
);
	import md5_pkg::*;

	cmd_t    cmd;
	status_t stat;

	md5_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	md5_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (item.data_byte),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule
`default_nettype wire
